>>> hdl/trd_pkg.sv
// shared types and constants of the triangle rasterizer with depth test
package trd_pkg;

  localparam int PCW    = 11;          // pixel coordinate, screens up to 2048
  localparam int EW     = 44;          // edge function accumulators
  localparam int EDW    = 18;          // edge coefficients in doubled units
  localparam int NW     = 37;          // barycentric weights and their sum
  localparam int NLO    = 19;          // low slice of a weight per multiply
  localparam int NHI    = NW - NLO;
  localparam int ZW     = 24;          // depth and packed color width
  localparam int PRW    = NLO + ZW;    // partial product
  localparam int ACCW   = NW + ZW;     // weighted sum
  localparam int SHW    = 48;
  localparam int CNTW   = 17;
  localparam int MW     = 2 * ZW;      // pixel word: depth over color

  localparam logic [CNTW-1:0] COUNT_MAX = '1;
  localparam logic [ZW-1:0]   DEPTH_FAR = '1;

  typedef enum logic [1:0] {
    KIND_DRAW  = 2'd0,
    KIND_CLEAR = 2'd1,
    KIND_READ  = 2'd2
  } kind_t;

  typedef enum logic [2:0] {
    OP_NONE,
    OP_CULL,
    OP_DRAW,
    OP_CLEAR,
    OP_READ
  } op_t;

  typedef struct packed {
    logic [1:0]         kind;
    logic signed [15:0] v0_x;
    logic signed [15:0] v0_y;
    logic signed [15:0] v1_x;
    logic signed [15:0] v1_y;
    logic signed [15:0] v2_x;
    logic signed [15:0] v2_y;
    logic [SHW-1:0]     v0_shade;
    logic [SHW-1:0]     v1_shade;
    logic [SHW-1:0]     v2_shade;
  } in_item_t;

  typedef struct packed {
    logic [CNTW-1:0] pixels_written;
    logic            culled;
    logic [ZW-1:0]   read_color;
    logic [ZW-1:0]   read_depth;
  } out_item_t;

  typedef struct packed {
    op_t                    op;
    logic [PCW-1:0]         x0;
    logic [PCW-1:0]         x1;
    logic [PCW-1:0]         y0;
    logic [PCW-1:0]         y1;
    logic [2:0][EW-1:0]     w;
    logic [2:0][EDW-1:0]    ea;
    logic [2:0][EDW-1:0]    eb;
    logic [NW-1:0]          den;
    logic [2:0][SHW-1:0]    shade;
  } desc_t;

  typedef enum logic [1:0] {F_IDLE, F_SETUP, F_PUSH} front_st_t;

  typedef enum logic [3:0] {
    B_INIT, B_IDLE, B_CLEAR, B_READ, B_RDWAIT, B_SCAN, B_SHADE, B_TEST, B_DONE
  } back_st_t;

  typedef enum logic [2:0] {I_IDLE, I_MAC, I_LOAD, I_DIV, I_DONE} interp_st_t;

endpackage

>>> hdl/triangle_raster_depth_test.sv
// top level of the triangle rasterizer with depth test
//
// a beat on start is taken when busy is low; every beat gives exactly one
// result, shown on out_result for the single cycle that out_valid is high,
// and results leave in the order the beats came in. after reset the block
// sweeps its frame store to far depth and black, one pixel a cycle, so busy
// stays high until all SCREEN_WIDTH*SCREEN_HEIGHT pixels (65536 at the
// defaults) are swept. the front end takes a beat, decodes it and clamps
// its box, and for a draw works out area, culling and edge setup on
// one shared multiplier; a two entry queue lets it take the next beat while
// the back end still works. in the back end a clear sweeps the store through
// its one write port, a read waits for the registered store data, and a
// culled or empty draw only reports its result. a draw walks its clamped
// bounding box, passing over pixels outside the triangle and sending each
// covered one through the interpolator (a serial multiply for the weighted
// sums, then a radix-2 divider of 24 steps for depth and color together).
module triangle_raster_depth_test #(
  parameter int SCREEN_WIDTH  = 256,
  parameter int SCREEN_HEIGHT = 256,
  parameter int SUBPIXEL_BITS = 4
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    start,
  output logic                    busy,
  input  trd_pkg::in_item_t       in_item,
  output logic                    out_valid,
  output trd_pkg::out_item_t      out_result,
  input  logic                    cfg_we,
  input  logic [trd_pkg::ZW-1:0]  cfg_wdata
);
  localparam int PIX = SCREEN_WIDTH * SCREEN_HEIGHT;
  localparam int AW  = (PIX > 1) ? $clog2(PIX) : 1;

  // backdrop color register
  logic [trd_pkg::ZW-1:0] backdrop_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      backdrop_r <= '0;
    end else if (cfg_we) begin
      backdrop_r <= cfg_wdata;
    end
  end

  // front to queue
  logic           q_push, q_full, q_empty, q_pop, init_active;
  trd_pkg::desc_t push_desc, q_head;

  trd_front #(
    .SCREEN_WIDTH (SCREEN_WIDTH),
    .SCREEN_HEIGHT(SCREEN_HEIGHT),
    .SUBPIXEL_BITS(SUBPIXEL_BITS)
  ) u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .hold   (init_active),
    .in_item(in_item),
    .q_full (q_full),
    .busy   (busy),
    .q_push (q_push),
    .q_desc (push_desc)
  );

  trd_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_desc(push_desc),
    .pop      (q_pop),
    .head     (q_head),
    .full     (q_full),
    .empty    (q_empty)
  );

  // frame store: depth in the upper half of each word, color in the lower
  logic                         ram_we, ram_re;
  logic [AW-1:0]                ram_waddr, ram_raddr;
  logic [trd_pkg::MW-1:0]       ram_wdata, ram_rdata;

  trd_ram #(
    .WIDTH(trd_pkg::MW),
    .DEPTH(PIX)
  ) u_store (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .re   (ram_re),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  // interpolator shared by every covered pixel
  logic                         ip_start, ip_done;
  logic [2:0][trd_pkg::NW-1:0]  ip_n;
  logic [trd_pkg::NW-1:0]       ip_den;
  logic [2:0][trd_pkg::SHW-1:0] ip_shade;
  logic [trd_pkg::ZW-1:0]       ip_z, ip_color;

  trd_interp u_interp (
    .clk  (clk),
    .rst_n(rst_n),
    .start(ip_start),
    .n    (ip_n),
    .den  (ip_den),
    .shade(ip_shade),
    .done (ip_done),
    .z    (ip_z),
    .color(ip_color)
  );

  trd_back #(
    .SCREEN_WIDTH (SCREEN_WIDTH),
    .SCREEN_HEIGHT(SCREEN_HEIGHT),
    .SUBPIXEL_BITS(SUBPIXEL_BITS)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_empty    (q_empty),
    .q_head     (q_head),
    .q_pop      (q_pop),
    .backdrop   (backdrop_r),
    .ram_we     (ram_we),
    .ram_waddr  (ram_waddr),
    .ram_wdata  (ram_wdata),
    .ram_re     (ram_re),
    .ram_raddr  (ram_raddr),
    .ram_rdata  (ram_rdata),
    .ip_start   (ip_start),
    .ip_n       (ip_n),
    .ip_den     (ip_den),
    .ip_shade   (ip_shade),
    .ip_done    (ip_done),
    .ip_z       (ip_z),
    .ip_color   (ip_color),
    .init_active(init_active),
    .out_valid  (out_valid),
    .out_result (out_result)
  );

  // no result can leave while the store is still being swept after reset
  a_init_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    init_active |-> !out_valid)
    else $error("result during reset sweep");

  // a taken beat keeps the front end busy in the next cycle
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("front end free right after a beat");

  // the front end never writes into a full queue
  a_queue_room: assert property (@(posedge clk) disable iff (!rst_n)
    q_push |-> !q_full)
    else $error("queue overrun");

  // a culled triangle draws nothing
  a_cull_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_result.culled) |-> (out_result.pixels_written == '0))
    else $error("culled triangle reports pixels");

endmodule

>>> hdl/trd_ram.sv
// generic single write port ram with registered read
module trd_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 65536,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic                 clk,
  input  logic                 we,
  input  logic [AW-1:0]        waddr,
  input  logic [WIDTH-1:0]     wdata,
  input  logic                 re,
  input  logic [AW-1:0]        raddr,
  output logic [WIDTH-1:0]     rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end
endmodule

>>> hdl/trd_front.sv
// front end: accepts items, culls, clamps the box and sets up edge functions
module trd_front #(
  parameter int SCREEN_WIDTH  = 256,
  parameter int SCREEN_HEIGHT = 256,
  parameter int SUBPIXEL_BITS = 4
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic              hold,
  input  trd_pkg::in_item_t in_item,
  input  logic              q_full,
  output logic              busy,
  output logic              q_push,
  output trd_pkg::desc_t    q_desc
);
  localparam int S = 1 << SUBPIXEL_BITS;

  trd_pkg::front_st_t state_r, state_nxt;
  trd_pkg::in_item_t  item_r;
  trd_pkg::op_t       op_r;
  logic [3:0]                  step_r;
  logic [trd_pkg::PCW-1:0]     bx0_r, bx1_r, by0_r, by1_r;
  logic                        empty_r;
  logic signed [39:0]          prod_r, acc_r, area_r;
  logic signed [trd_pkg::EW-1:0] w_r [3];

  // box and read position from the incoming beat
  logic signed [15:0] xmin, xmax, ymin, ymax;
  logic signed [16:0] fx0, fx1, fy0, fy1, cx0c, cx1c, cy0c, cy1c, rx, ry;
  logic               box_empty, rd_in;

  always_comb begin
    xmin = in_item.v0_x; xmax = in_item.v0_x;
    ymin = in_item.v0_y; ymax = in_item.v0_y;
    if (in_item.v1_x < xmin) xmin = in_item.v1_x;
    if (in_item.v2_x < xmin) xmin = in_item.v2_x;
    if (in_item.v1_x > xmax) xmax = in_item.v1_x;
    if (in_item.v2_x > xmax) xmax = in_item.v2_x;
    if (in_item.v1_y < ymin) ymin = in_item.v1_y;
    if (in_item.v2_y < ymin) ymin = in_item.v2_y;
    if (in_item.v1_y > ymax) ymax = in_item.v1_y;
    if (in_item.v2_y > ymax) ymax = in_item.v2_y;
    fx0  = 17'(xmin) >>> SUBPIXEL_BITS;
    fy0  = 17'(ymin) >>> SUBPIXEL_BITS;
    fx1  = (17'(xmax) + 17'(S - 1)) >>> SUBPIXEL_BITS;
    fy1  = (17'(ymax) + 17'(S - 1)) >>> SUBPIXEL_BITS;
    cx0c = (fx0 < 0) ? 17'sd0 : fx0;
    cy0c = (fy0 < 0) ? 17'sd0 : fy0;
    cx1c = (fx1 > SCREEN_WIDTH - 1)  ? 17'(SCREEN_WIDTH - 1)  : fx1;
    cy1c = (fy1 > SCREEN_HEIGHT - 1) ? 17'(SCREEN_HEIGHT - 1) : fy1;
    box_empty = (cx0c > cx1c) || (cy0c > cy1c);
    rx = 17'(in_item.v0_x) >>> SUBPIXEL_BITS;
    ry = 17'(in_item.v0_y) >>> SUBPIXEL_BITS;
    rd_in = (rx >= 0) && (rx < SCREEN_WIDTH) && (ry >= 0) && (ry < SCREEN_HEIGHT);
  end

  // doubled vertex coordinates and edge coefficients
  logic signed [16:0] dxv [3];
  logic signed [16:0] dyv [3];
  logic signed [16:0] dx10, dy10, dx20, dy20;
  logic signed [trd_pkg::EDW-1:0] ea [3];
  logic signed [trd_pkg::EDW-1:0] eb [3];
  logic signed [21:0] cxs, cys;
  logic signed [trd_pkg::EDW-1:0] ma;
  logic signed [21:0] mb;

  always_comb begin
    dxv[0] = {item_r.v0_x, 1'b0}; dyv[0] = {item_r.v0_y, 1'b0};
    dxv[1] = {item_r.v1_x, 1'b0}; dyv[1] = {item_r.v1_y, 1'b0};
    dxv[2] = {item_r.v2_x, 1'b0}; dyv[2] = {item_r.v2_y, 1'b0};
    dx10 = 17'(item_r.v1_x) - 17'(item_r.v0_x);
    dy10 = 17'(item_r.v1_y) - 17'(item_r.v0_y);
    dx20 = 17'(item_r.v2_x) - 17'(item_r.v0_x);
    dy20 = 17'(item_r.v2_y) - 17'(item_r.v0_y);
    // edge e runs from vertex e+1 to vertex e+2
    ea[0] = 18'(dxv[2]) - 18'(dxv[1]); eb[0] = 18'(dyv[2]) - 18'(dyv[1]);
    ea[1] = 18'(dxv[0]) - 18'(dxv[2]); eb[1] = 18'(dyv[0]) - 18'(dyv[2]);
    ea[2] = 18'(dxv[1]) - 18'(dxv[0]); eb[2] = 18'(dyv[1]) - 18'(dyv[0]);
    // first pixel center in doubled units
    cxs = $signed(22'({bx0_r, 1'b1}) << SUBPIXEL_BITS);
    cys = $signed(22'({by0_r, 1'b1}) << SUBPIXEL_BITS);
    case (step_r)
      4'd0: begin ma = 18'(dx10); mb = 22'(dy20); end
      4'd1: begin ma = 18'(dy10); mb = 22'(dx20); end
      4'd2: begin ma = ea[0]; mb = cys - 22'(dyv[1]); end
      4'd3: begin ma = eb[0]; mb = cxs - 22'(dxv[1]); end
      4'd4: begin ma = ea[1]; mb = cys - 22'(dyv[2]); end
      4'd5: begin ma = eb[1]; mb = cxs - 22'(dxv[2]); end
      4'd6: begin ma = ea[2]; mb = cys - 22'(dyv[0]); end
      4'd7: begin ma = eb[2]; mb = cxs - 22'(dxv[0]); end
      default: begin ma = '0; mb = '0; end
    endcase
  end

  logic accept;
  assign accept = start && !busy;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      trd_pkg::F_IDLE: begin
        if (accept) begin
          state_nxt = (in_item.kind == trd_pkg::KIND_DRAW) ? trd_pkg::F_SETUP
                                                           : trd_pkg::F_PUSH;
        end
      end
      trd_pkg::F_SETUP: begin
        if ((step_r == 4'd3 && (area_r >= 0 || empty_r)) || step_r == 4'd8) begin
          state_nxt = trd_pkg::F_PUSH;
        end
      end
      trd_pkg::F_PUSH: begin
        if (!q_full) state_nxt = trd_pkg::F_IDLE;
      end
      default: state_nxt = trd_pkg::F_IDLE;
    endcase
  end

  logic signed [39:0] nden;

  always_comb begin
    busy   = (state_r != trd_pkg::F_IDLE) || hold;
    q_push = (state_r == trd_pkg::F_PUSH) && !q_full;
    nden   = -(area_r <<< 2);
    q_desc.op    = op_r;
    q_desc.x0    = bx0_r;
    q_desc.x1    = bx1_r;
    q_desc.y0    = by0_r;
    q_desc.y1    = by1_r;
    q_desc.den   = nden[trd_pkg::NW-1:0];
    q_desc.shade = {item_r.v2_shade, item_r.v1_shade, item_r.v0_shade};
    for (int e = 0; e < 3; e++) begin
      q_desc.w[e]  = w_r[e];
      q_desc.ea[e] = ea[e];
      q_desc.eb[e] = eb[e];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= trd_pkg::F_IDLE;
      step_r  <= '0;
      op_r    <= trd_pkg::OP_NONE;
    end else begin
      state_r <= state_nxt;
      if (accept) begin
        item_r  <= in_item;
        step_r  <= '0;
        empty_r <= box_empty;
        bx1_r   <= cx1c[trd_pkg::PCW-1:0];
        by1_r   <= cy1c[trd_pkg::PCW-1:0];
        if (in_item.kind == trd_pkg::KIND_READ) begin
          bx0_r <= rx[trd_pkg::PCW-1:0];
          by0_r <= ry[trd_pkg::PCW-1:0];
        end else begin
          bx0_r <= cx0c[trd_pkg::PCW-1:0];
          by0_r <= cy0c[trd_pkg::PCW-1:0];
        end
        case (in_item.kind)
          trd_pkg::KIND_CLEAR: op_r <= trd_pkg::OP_CLEAR;
          trd_pkg::KIND_READ:  op_r <= rd_in ? trd_pkg::OP_READ : trd_pkg::OP_NONE;
          trd_pkg::KIND_DRAW:  op_r <= trd_pkg::OP_DRAW;
          default:             op_r <= trd_pkg::OP_NONE;
        endcase
      end
      if (state_r == trd_pkg::F_SETUP) begin
        step_r <= step_r + 4'd1;
        prod_r <= ma * mb;
        case (step_r)
          4'd1, 4'd3, 4'd5, 4'd7: acc_r <= prod_r;
          4'd2: area_r <= acc_r - prod_r;
          4'd4: w_r[0] <= trd_pkg::EW'(acc_r) - trd_pkg::EW'(prod_r);
          4'd6: w_r[1] <= trd_pkg::EW'(acc_r) - trd_pkg::EW'(prod_r);
          4'd8: w_r[2] <= trd_pkg::EW'(acc_r) - trd_pkg::EW'(prod_r);
          default: ;
        endcase
        if (step_r == 4'd3) begin
          if (area_r >= 0)  op_r <= trd_pkg::OP_CULL;
          else if (empty_r) op_r <= trd_pkg::OP_NONE;
        end
      end
    end
  end
endmodule

>>> hdl/trd_queue.sv
// two entry queue of set-up work between front and back
module trd_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  trd_pkg::desc_t push_desc,
  input  logic           pop,
  output trd_pkg::desc_t head,
  output logic           full,
  output logic           empty
);
  trd_pkg::desc_t mem_r [2];
  logic       wptr_r, rptr_r;
  logic [1:0] cnt_r;

  assign head  = mem_r[rptr_r];
  assign full  = (cnt_r == 2'd2);
  assign empty = (cnt_r == 2'd0);

  always_ff @(posedge clk) begin
    if (push) mem_r[wptr_r] <= push_desc;
    if (!rst_n) begin
      wptr_r <= 1'b0;
      rptr_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      if (push) wptr_r <= !wptr_r;
      if (pop)  rptr_r <= !rptr_r;
      cnt_r <= cnt_r + 2'(push) - 2'(pop);
    end
  end
endmodule

>>> hdl/trd_interp.sv
// barycentric interpolation of depth and color, serial multiply then divide
module trd_interp (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  input  logic [2:0][trd_pkg::NW-1:0]  n,
  input  logic [trd_pkg::NW-1:0]       den,
  input  logic [2:0][trd_pkg::SHW-1:0] shade,
  output logic                         done,
  output logic [trd_pkg::ZW-1:0]       z,
  output logic [trd_pkg::ZW-1:0]       color
);
  localparam int ZW = trd_pkg::ZW;

  trd_pkg::interp_st_t state_r, state_nxt;
  logic [4:0]                cnt_r;
  logic [2:0][trd_pkg::NW-1:0] n_r;
  logic [trd_pkg::NW-1:0]    den_r;
  logic [ZW-1:0]             val_r  [4][3];
  logic [trd_pkg::PRW-1:0]   prod_r [4];
  logic [trd_pkg::ACCW-1:0]  acc_r  [4];
  logic [trd_pkg::NW-1:0]    rem_r  [4];
  logic [ZW-1:0]             lo_r   [4];
  logic [ZW-1:0]             q_r    [4];

  logic [trd_pkg::NLO-1:0]   part;
  logic [trd_pkg::NW:0]      rem2 [4];
  logic                      ge   [4];

  always_comb begin
    if (cnt_r[0]) part = trd_pkg::NLO'(n_r[cnt_r[2:1]][trd_pkg::NW-1:trd_pkg::NLO]);
    else          part = n_r[cnt_r[2:1]][trd_pkg::NLO-1:0];
    for (int l = 0; l < 4; l++) begin
      rem2[l] = {rem_r[l], lo_r[l][ZW-1]};
      ge[l]   = (rem2[l] >= {1'b0, den_r});
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      trd_pkg::I_IDLE: if (start) state_nxt = trd_pkg::I_MAC;
      trd_pkg::I_MAC:  if (cnt_r == 5'd6) state_nxt = trd_pkg::I_LOAD;
      trd_pkg::I_LOAD: state_nxt = trd_pkg::I_DIV;
      trd_pkg::I_DIV:  if (cnt_r == 5'(ZW - 1)) state_nxt = trd_pkg::I_DONE;
      trd_pkg::I_DONE: state_nxt = trd_pkg::I_IDLE;
      default:         state_nxt = trd_pkg::I_IDLE;
    endcase
  end

  always_comb begin
    done  = (state_r == trd_pkg::I_DONE);
    z     = q_r[0];
    color = {q_r[3][7:0], q_r[2][7:0], q_r[1][7:0]};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= trd_pkg::I_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      case (state_r)
        trd_pkg::I_IDLE: begin
          cnt_r <= '0;
          if (start) begin
            n_r   <= n;
            den_r <= den;
            for (int i = 0; i < 3; i++) begin
              val_r[0][i] <= shade[i][47:24];
              val_r[1][i] <= ZW'(shade[i][7:0]);
              val_r[2][i] <= ZW'(shade[i][15:8]);
              val_r[3][i] <= ZW'(shade[i][23:16]);
            end
            for (int l = 0; l < 4; l++) acc_r[l] <= '0;
          end
        end
        trd_pkg::I_MAC: begin
          cnt_r <= (cnt_r == 5'd6) ? 5'd0 : cnt_r + 5'd1;
          for (int l = 0; l < 4; l++) begin
            if (cnt_r != 5'd6) prod_r[l] <= part * val_r[l][cnt_r[2:1]];
            if (cnt_r != 5'd0) begin
              // odd count consumes a low slice, even a high slice
              if (cnt_r[0]) acc_r[l] <= acc_r[l] + trd_pkg::ACCW'(prod_r[l]);
              else acc_r[l] <= acc_r[l] + (trd_pkg::ACCW'(prod_r[l]) << trd_pkg::NLO);
            end
          end
        end
        trd_pkg::I_LOAD: begin
          for (int l = 0; l < 4; l++) begin
            rem_r[l] <= acc_r[l][trd_pkg::ACCW-1:ZW];
            lo_r[l]  <= acc_r[l][ZW-1:0];
            q_r[l]   <= '0;
          end
        end
        trd_pkg::I_DIV: begin
          cnt_r <= cnt_r + 5'd1;
          for (int l = 0; l < 4; l++) begin
            rem_r[l] <= ge[l] ? trd_pkg::NW'(rem2[l] - {1'b0, den_r})
                              : trd_pkg::NW'(rem2[l]);
            lo_r[l]  <= {lo_r[l][ZW-2:0], 1'b0};
            q_r[l]   <= {q_r[l][ZW-2:0], ge[l]};
          end
        end
        default: ;
      endcase
    end
  end
endmodule

>>> hdl/trd_back.sv
// back end: clear sweeps, pixel reads and the bounding box walk with depth test
module trd_back #(
  parameter int SCREEN_WIDTH  = 256,
  parameter int SCREEN_HEIGHT = 256,
  parameter int SUBPIXEL_BITS = 4,
  localparam int AW = (SCREEN_WIDTH * SCREEN_HEIGHT > 1) ?
                      $clog2(SCREEN_WIDTH * SCREEN_HEIGHT) : 1
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         q_empty,
  input  trd_pkg::desc_t               q_head,
  output logic                         q_pop,
  input  logic [trd_pkg::ZW-1:0]       backdrop,
  output logic                         ram_we,
  output logic [AW-1:0]                ram_waddr,
  output logic [trd_pkg::MW-1:0]       ram_wdata,
  output logic                         ram_re,
  output logic [AW-1:0]                ram_raddr,
  input  logic [trd_pkg::MW-1:0]       ram_rdata,
  output logic                         ip_start,
  output logic [2:0][trd_pkg::NW-1:0]  ip_n,
  output logic [trd_pkg::NW-1:0]       ip_den,
  output logic [2:0][trd_pkg::SHW-1:0] ip_shade,
  input  logic                         ip_done,
  input  logic [trd_pkg::ZW-1:0]       ip_z,
  input  logic [trd_pkg::ZW-1:0]       ip_color,
  output logic                         init_active,
  output logic                         out_valid,
  output trd_pkg::out_item_t           out_result
);
  localparam int PIX = SCREEN_WIDTH * SCREEN_HEIGHT;
  localparam logic [AW-1:0] ADDR_LAST = AW'(PIX - 1);
  localparam int EW  = trd_pkg::EW;
  localparam int ZW  = trd_pkg::ZW;

  trd_pkg::back_st_t state_r, state_nxt;
  trd_pkg::desc_t    d_r;
  logic [AW-1:0]                addr_r;
  logic [trd_pkg::PCW-1:0]      px_r, py_r;
  logic signed [EW-1:0]         w_r [3];
  logic signed [EW-1:0]         wrow_r [3];
  logic [trd_pkg::CNTW-1:0]     count_r;
  logic [trd_pkg::MW-1:0]       rd_r;

  logic signed [EW-1:0] stepx [3];
  logic signed [EW-1:0] stepy [3];
  logic                 covered, last_x, last, z_pass, advance;
  logic [AW-1:0]        pix_idx;

  always_comb begin
    covered = 1'b1;
    for (int e = 0; e < 3; e++) begin
      stepx[e] = -(EW'($signed(d_r.eb[e])) <<< (SUBPIXEL_BITS + 1));
      stepy[e] =   EW'($signed(d_r.ea[e])) <<< (SUBPIXEL_BITS + 1);
      if (w_r[e] > 0) covered = 1'b0;
      ip_n[e] = trd_pkg::NW'(-w_r[e]);
    end
    last_x  = (px_r == d_r.x1);
    last    = last_x && (py_r == d_r.y1);
    pix_idx = AW'(32'(py_r) * SCREEN_WIDTH + 32'(px_r));
    z_pass  = (ip_z < ram_rdata[trd_pkg::MW-1:ZW]);
    advance = (state_r == trd_pkg::B_TEST) ||
              ((state_r == trd_pkg::B_SCAN) && !covered);
    ip_den   = d_r.den;
    ip_shade = d_r.shade;
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      trd_pkg::B_INIT:  if (addr_r == ADDR_LAST) state_nxt = trd_pkg::B_IDLE;
      trd_pkg::B_IDLE: begin
        if (!q_empty) begin
          case (q_head.op)
            trd_pkg::OP_CLEAR: state_nxt = trd_pkg::B_CLEAR;
            trd_pkg::OP_READ:  state_nxt = trd_pkg::B_READ;
            trd_pkg::OP_DRAW:  state_nxt = trd_pkg::B_SCAN;
            default:           state_nxt = trd_pkg::B_DONE;
          endcase
        end
      end
      trd_pkg::B_CLEAR:  if (addr_r == ADDR_LAST) state_nxt = trd_pkg::B_DONE;
      trd_pkg::B_READ:   state_nxt = trd_pkg::B_RDWAIT;
      trd_pkg::B_RDWAIT: state_nxt = trd_pkg::B_DONE;
      trd_pkg::B_SCAN: begin
        if (covered)   state_nxt = trd_pkg::B_SHADE;
        else if (last) state_nxt = trd_pkg::B_DONE;
      end
      trd_pkg::B_SHADE:  if (ip_done) state_nxt = trd_pkg::B_TEST;
      trd_pkg::B_TEST:   state_nxt = last ? trd_pkg::B_DONE : trd_pkg::B_SCAN;
      trd_pkg::B_DONE:   state_nxt = trd_pkg::B_IDLE;
      default:           state_nxt = trd_pkg::B_IDLE;
    endcase
  end

  always_comb begin
    q_pop       = (state_r == trd_pkg::B_IDLE) && !q_empty;
    init_active = (state_r == trd_pkg::B_INIT);
    ram_we      = 1'b0;
    ram_waddr   = addr_r;
    ram_wdata   = {trd_pkg::DEPTH_FAR, backdrop};
    ram_re      = 1'b0;
    ram_raddr   = pix_idx;
    ip_start    = 1'b0;
    case (state_r)
      trd_pkg::B_INIT: begin
        ram_we    = 1'b1;
        ram_wdata = {trd_pkg::DEPTH_FAR, {ZW{1'b0}}};
      end
      trd_pkg::B_CLEAR: ram_we = 1'b1;
      trd_pkg::B_READ:  ram_re = 1'b1;
      trd_pkg::B_SCAN: begin
        ram_re   = covered;
        ip_start = covered;
      end
      trd_pkg::B_TEST: begin
        ram_we    = z_pass;
        ram_waddr = pix_idx;
        ram_wdata = {ip_z, ip_color};
      end
      default: ;
    endcase
    out_valid = (state_r == trd_pkg::B_DONE);
    out_result.pixels_written = (d_r.op == trd_pkg::OP_DRAW) ? count_r : '0;
    out_result.culled         = (d_r.op == trd_pkg::OP_CULL);
    out_result.read_color     = (d_r.op == trd_pkg::OP_READ) ? rd_r[ZW-1:0] : '0;
    out_result.read_depth     = (d_r.op == trd_pkg::OP_READ) ?
                                rd_r[trd_pkg::MW-1:ZW] : '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= trd_pkg::B_INIT;
      addr_r  <= '0;
      count_r <= '0;
      d_r.op  <= trd_pkg::OP_NONE;
    end else begin
      state_r <= state_nxt;
      if (q_pop) begin
        d_r     <= q_head;
        px_r    <= q_head.x0;
        py_r    <= q_head.y0;
        addr_r  <= '0;
        count_r <= '0;
        for (int e = 0; e < 3; e++) begin
          w_r[e]    <= q_head.w[e];
          wrow_r[e] <= q_head.w[e];
        end
      end
      if (state_r == trd_pkg::B_INIT || state_r == trd_pkg::B_CLEAR) begin
        addr_r <= addr_r + AW'(1);
      end
      if (state_r == trd_pkg::B_RDWAIT) rd_r <= ram_rdata;
      if (state_r == trd_pkg::B_TEST && z_pass && count_r != trd_pkg::COUNT_MAX) begin
        count_r <= count_r + trd_pkg::CNTW'(1);
      end
      if (advance) begin
        if (!last_x) begin
          px_r <= px_r + trd_pkg::PCW'(1);
          for (int e = 0; e < 3; e++) w_r[e] <= w_r[e] + stepx[e];
        end else begin
          px_r <= d_r.x0;
          py_r <= py_r + trd_pkg::PCW'(1);
          for (int e = 0; e < 3; e++) begin
            w_r[e]    <= wrow_r[e] + stepy[e];
            wrow_r[e] <= wrow_r[e] + stepy[e];
          end
        end
      end
    end
  end
endmodule

>>> dv/testbench.sv
// self-checking testbench for the triangle rasterizer with depth test
module testbench;

  localparam int SCR_W = 256;
  localparam int SCR_H = 256;
  localparam int SUB = 16;                       // one pixel in 12.4 units
  localparam longint CYCLE_LIMIT = 8_000_000;    // each clear sweeps all 64k pixels
  localparam logic [1:0] KIND_UNUSED = 2'd3;
  localparam int PHASES = 4;
  localparam int PHASE_BEATS = 440;

  logic clk;
  logic rst_n;
  logic start;
  logic busy;
  trd_pkg::in_item_t in_item;
  logic out_valid;
  trd_pkg::out_item_t out_result;
  logic cfg_we;
  logic [trd_pkg::ZW-1:0] cfg_wdata;
  longint cycles;

  triangle_raster_depth_test dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_item(in_item),
    .out_valid(out_valid), .out_result(out_result), .cfg_we(cfg_we),
    .cfg_wdata(cfg_wdata)
  );

  // mirror of the frame and depth stores plus the queue of pending results
  class raster_scoreboard;
    bit [23:0] depth_mem[SCR_W*SCR_H];
    bit [23:0] color_mem[SCR_W*SCR_H];
    bit [23:0] backdrop;
    trd_pkg::out_item_t pending[$];
    int errors;

    function new();
      foreach (depth_mem[i]) begin
        depth_mem[i] = '1;
        color_mem[i] = '0;
      end
      backdrop = '0;
      errors = 0;
    endfunction

    // doubled signed area, negative for a drawable triangle
    function longint signed_area(trd_pkg::in_item_t it);
      longint ax, ay, bx, by, cx, cy;
      ax = it.v0_x; ay = it.v0_y; bx = it.v1_x; by = it.v1_y;
      cx = it.v2_x; cy = it.v2_y;
      return (bx - ax) * (cy - ay) - (by - ay) * (cx - ax);
    endfunction

    function bit [23:0] blend(longint unsigned n0, longint unsigned n1,
                              longint unsigned n2, longint unsigned den,
                              bit [23:0] a, bit [23:0] b, bit [23:0] c);
      longint unsigned a64, b64, c64;
      a64 = a; b64 = b; c64 = c;
      return 24'((n0 * a64 + n1 * b64 + n2 * c64) / den);
    endfunction

    function void rasterize(trd_pkg::in_item_t it, ref trd_pkg::out_item_t r);
      longint vx[3], vy[3], area, bx0, bx1, by0, by1, cx, cy, w[3];
      longint unsigned den, n[3];
      bit [47:0] sh[3];
      bit [23:0] z;
      bit [7:0] ch[3];
      int idx;
      vx[0] = it.v0_x; vy[0] = it.v0_y;
      vx[1] = it.v1_x; vy[1] = it.v1_y;
      vx[2] = it.v2_x; vy[2] = it.v2_y;
      sh[0] = it.v0_shade; sh[1] = it.v1_shade; sh[2] = it.v2_shade;
      area = signed_area(it);
      if (area >= 0) begin
        r.culled = 1'b1;
        return;
      end
      // box in whole pixels: floor of the minimum, ceiling of the maximum
      bx0 = vx[0]; bx1 = vx[0]; by0 = vy[0]; by1 = vy[0];
      for (int i = 1; i < 3; i++) begin
        if (vx[i] < bx0) bx0 = vx[i];
        if (vx[i] > bx1) bx1 = vx[i];
        if (vy[i] < by0) by0 = vy[i];
        if (vy[i] > by1) by1 = vy[i];
      end
      bx0 = bx0 >>> 4; by0 = by0 >>> 4;
      bx1 = -((-bx1) >>> 4); by1 = -((-by1) >>> 4);
      if (bx0 < 0) bx0 = 0;
      if (by0 < 0) by0 = 0;
      if (bx1 > SCR_W - 1) bx1 = SCR_W - 1;
      if (by1 > SCR_H - 1) by1 = SCR_H - 1;
      den = longint'(-(area * 4));
      for (longint py = by0; py <= by1; py++) begin
        cy = (2 * py + 1) * SUB;
        for (longint px = bx0; px <= bx1; px++) begin
          cx = (2 * px + 1) * SUB;
          // edge functions in doubled units, edges inclusive
          for (int e = 0; e < 3; e++) begin
            int p, q;
            p = (e + 1) % 3; q = (e + 2) % 3;
            w[e] = (2 * vx[q] - 2 * vx[p]) * (cy - 2 * vy[p])
                 - (2 * vy[q] - 2 * vy[p]) * (cx - 2 * vx[p]);
          end
          if (w[0] > 0 || w[1] > 0 || w[2] > 0) continue;
          for (int e = 0; e < 3; e++) n[e] = longint'(-w[e]);
          z = blend(n[0], n[1], n[2], den, sh[0][47:24], sh[1][47:24], sh[2][47:24]);
          idx = int'(py) * SCR_W + int'(px);
          if (z < depth_mem[idx]) begin
            for (int c = 0; c < 3; c++)
              ch[c] = 8'(blend(n[0], n[1], n[2], den, 24'(sh[0][8*c +: 8]),
                               24'(sh[1][8*c +: 8]), 24'(sh[2][8*c +: 8])));
            depth_mem[idx] = z;
            color_mem[idx] = {ch[2], ch[1], ch[0]};
            if (r.pixels_written != trd_pkg::COUNT_MAX) r.pixels_written++;
          end
        end
      end
    endfunction

    function void note_beat(trd_pkg::in_item_t it);
      trd_pkg::out_item_t r;
      longint px, py;
      r = '0;
      case (it.kind)
        trd_pkg::KIND_DRAW: rasterize(it, r);
        trd_pkg::KIND_CLEAR: begin
          foreach (depth_mem[i]) begin
            depth_mem[i] = '1;
            color_mem[i] = backdrop;
          end
        end
        trd_pkg::KIND_READ: begin
          px = longint'(it.v0_x) >>> 4;
          py = longint'(it.v0_y) >>> 4;
          if (px >= 0 && px < SCR_W && py >= 0 && py < SCR_H) begin
            r.read_color = color_mem[py * SCR_W + px];
            r.read_depth = depth_mem[py * SCR_W + px];
          end
        end
        default: ;
      endcase
      pending.insert(pending.size(), r);
    endfunction

    function void check_result(trd_pkg::out_item_t got);
      trd_pkg::out_item_t want;
      if (pending.size() == 0) begin
        $display("%0t unexpected result %h", $time, got);
        errors++;
        return;
      end
      want = pending.pop_front();
      if (got.pixels_written !== want.pixels_written) begin
        $display("%0t pixels_written exp %0d got %0d", $time,
                 want.pixels_written, got.pixels_written);
        errors++;
      end
      if (got.culled !== want.culled) begin
        $display("%0t culled exp %0b got %0b", $time, want.culled, got.culled);
        errors++;
      end
      if (got.read_color !== want.read_color) begin
        $display("%0t read_color exp %h got %h", $time, want.read_color, got.read_color);
        errors++;
      end
      if (got.read_depth !== want.read_depth) begin
        $display("%0t read_depth exp %h got %h", $time, want.read_depth, got.read_depth);
        errors++;
      end
    endfunction
  endclass

  raster_scoreboard sb;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // cycle budget, covers the reset sweep and every clear
  initial cycles = 0;
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // results cannot be held off, every strobe is one beat
  always @(posedge clk) begin
    if (rst_n && out_valid) sb.check_result(out_result);
  end

  // offer one beat from the falling edge until the block takes it; start
  // stays high so the next beat can follow without a gap
  task automatic send(trd_pkg::in_item_t it);
    start = 1'b1;
    in_item = it;
    do @(posedge clk); while (busy);
    sb.note_beat(it);
    @(negedge clk);
  endtask

  task automatic maybe_pause(bit allow);
    if (allow && $urandom_range(0, 3) == 0) begin
      start = 1'b0;
      repeat ($urandom_range(1, 14)) @(negedge clk);
    end
  endtask

  // register writes only once every pending result has drained
  task automatic write_backdrop(bit [23:0] v);
    start = 1'b0;
    while (sb.pending.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
    cfg_we = 1'b1;
    cfg_wdata = v;
    sb.backdrop = v;
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  function automatic bit [47:0] rand48();
    return {16'($urandom), $urandom};
  endfunction

  // the fields a draw ignores or a read ignores still get random content
  function automatic trd_pkg::in_item_t noise_item(logic [1:0] k);
    trd_pkg::in_item_t it;
    it.kind = k;
    it.v0_x = 16'($urandom); it.v0_y = 16'($urandom);
    it.v1_x = 16'($urandom); it.v1_y = 16'($urandom);
    it.v2_x = 16'($urandom); it.v2_y = 16'($urandom);
    it.v0_shade = rand48(); it.v1_shade = rand48(); it.v2_shade = rand48();
    return it;
  endfunction

  function automatic trd_pkg::in_item_t tri_item(int ax, int ay, int bx, int by,
                                                 int cx, int cy, bit [47:0] s0,
                                                 bit [47:0] s1, bit [47:0] s2);
    trd_pkg::in_item_t it;
    it.kind = trd_pkg::KIND_DRAW;
    it.v0_x = 16'(ax); it.v0_y = 16'(ay);
    it.v1_x = 16'(bx); it.v1_y = 16'(by);
    it.v2_x = 16'(cx); it.v2_y = 16'(cy);
    it.v0_shade = s0; it.v1_shade = s1; it.v2_shade = s2;
    return it;
  endfunction

  function automatic trd_pkg::in_item_t read_item(int x, int y);
    trd_pkg::in_item_t it;
    it = noise_item(trd_pkg::KIND_READ);
    it.v0_x = 16'(x);
    it.v0_y = 16'(y);
    return it;
  endfunction

  // small triangle near the top left, wound so that it draws
  function automatic trd_pkg::in_item_t small_tri();
    trd_pkg::in_item_t it;
    int bx, by;
    logic signed [15:0] tx, ty;
    bit [47:0] s[3];
    bx = $urandom_range(0, 56 * SUB) - 8 * SUB;
    by = $urandom_range(0, 56 * SUB) - 8 * SUB;
    for (int i = 0; i < 3; i++) begin
      s[i] = rand48();
      if ($urandom_range(0, 9) == 0) s[i][47:24] = '1;
    end
    it = tri_item(bx + $urandom_range(0, 96), by + $urandom_range(0, 96),
                  bx + $urandom_range(0, 96), by + $urandom_range(0, 96),
                  bx + $urandom_range(0, 96), by + $urandom_range(0, 96),
                  s[0], s[1], s[2]);
    if ($urandom_range(0, 5) == 0) begin
      it.v1_shade[23:0] = it.v0_shade[23:0];
      it.v2_shade[23:0] = it.v0_shade[23:0];
    end
    if (sb.signed_area(it) > 0) begin
      tx = it.v1_x; ty = it.v1_y;
      it.v1_x = it.v2_x; it.v1_y = it.v2_y;
      it.v2_x = tx; it.v2_y = ty;
    end
    return it;
  endfunction

  // full range coordinates, wound the culled way so the walk stays short
  function automatic trd_pkg::in_item_t wide_culled_tri();
    trd_pkg::in_item_t it;
    logic signed [15:0] tx, ty;
    it = noise_item(trd_pkg::KIND_DRAW);
    if (sb.signed_area(it) < 0) begin
      tx = it.v1_x; ty = it.v1_y;
      it.v1_x = it.v2_x; it.v1_y = it.v2_y;
      it.v2_x = tx; it.v2_y = ty;
    end
    return it;
  endfunction

  initial begin
    trd_pkg::in_item_t base;
    int pick;
    bit [23:0] bd;
    sb = new();
    start = 1'b0;
    in_item = '0;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    rst_n = 1'b0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // directed part
    send(read_item(5 * SUB, 5 * SUB));                 // untouched pixel: far and black
    base = tri_item(0, 0, 0, 160, 160, 0, {24'h000100, 24'h0000ff},
                    {24'h000200, 24'h00ff00}, {24'h000300, 24'hff0000});
    send(base);
    send(read_item(2 * SUB, 2 * SUB));
    send(base);                                        // equal depth never passes
    send(tri_item(0, 0, 0, 160, 160, 0, {24'h0, 24'h123456}, {24'h0, 24'h123456},
                  {24'h0, 24'h123456}));               // flat shaded, nearer
    send(read_item(SUB + 8, SUB + 8));
    send(tri_item(0, 0, 16, 16, 32, 32, rand48(), rand48(), rand48()));   // zero area
    send(tri_item(0, 0, 160, 0, 0, 160, rand48(), rand48(), rand48()));   // wrong winding
    send(tri_item(-400, 0, -400, 160, -200, 0, rand48(), rand48(), rand48()));
    send(tri_item(5000, 5000, 5000, 5160, 5160, 5000, rand48(), rand48(), rand48()));
    send(tri_item(320, 320, 320, 480, 480, 320, {24'hffffff, 24'h1},
                  {24'hffffff, 24'h2}, {24'hffffff, 24'h3}));           // far depth
    send(tri_item(-48, -48, -48, 80, 80, -48, {24'h000010, 24'habcdef},
                  {24'h000020, 24'h0}, {24'h000030, 24'hffffff}));      // clipped corner
    send(read_item(0, 0));
    send(read_item(-1, -1));
    send(read_item(SCR_W * SUB, 0));
    send(read_item(32767, -32768));
    send(noise_item(KIND_UNUSED));
    send(tri_item(-32768, -32768, 32767, -32768, -32768, 32767, rand48(), rand48(),
                  rand48()));
    write_backdrop(24'hffffff);
    send(noise_item(trd_pkg::KIND_CLEAR));
    send(read_item(10 * SUB, 10 * SUB));
    send(read_item((SCR_W - 1) * SUB + 15, (SCR_H - 1) * SUB + 15));

    // random phases, each under its own backdrop and starting from a clear
    for (int ph = 0; ph < PHASES; ph++) begin
      bd = (ph == 0) ? 24'h000000 : 24'($urandom);
      write_backdrop(bd);
      send(noise_item(trd_pkg::KIND_CLEAR));
      for (int n = 0; n < PHASE_BEATS; n++) begin
        pick = $urandom_range(0, 99);
        if (pick < 48) send(small_tri());
        else if (pick < 58) send(wide_culled_tri());
        else if (pick < 88)
          send(read_item($urandom_range(0, 60 * SUB) - 4 * SUB,
                         $urandom_range(0, 60 * SUB) - 4 * SUB));
        else if (pick < 96) send(noise_item(trd_pkg::KIND_READ));
        else send(noise_item(KIND_UNUSED));
        maybe_pause(ph != PHASES - 1);
      end
    end

    start = 1'b0;
    while (sb.pending.size() != 0) @(negedge clk);
    repeat (64) @(negedge clk);
    if (sb.errors == 0) $display("RESULT: OK");
    else $display("RESULT: ERROR");
    $finish;
  end
endmodule
